FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hdl/vtcp_pkg.sv
// ----------------------------------------------------------------------------
// vtcp_pkg
// shared types and constants of the vertex transform block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vtcp_pkg;
    localparam int NumRegs = 7;
    localparam int IdxW = 3;
    localparam logic [63:0] QuotCap = 64'h100_0000_0000;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
        logic               last_vertex;
    } vin_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         clip_code;
        logic [5:0]         codes_or;
        logic [5:0]         codes_and;
        logic               w_zero;
        logic               list_end;
    } vout_t;

    typedef struct packed {
        logic [IdxW-1:0] index;
        logic [63:0]     data;
    } cfg_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [63:0] num_hi;
        logic [63:0] num_lo;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/vtcp_if.sv
// ----------------------------------------------------------------------------
// vtcp_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface vtcp_vin_if;
    logic             valid;
    logic             ready;
    vtcp_pkg::vin_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vtcp_vout_if;
    logic             valid;
    logic             ready;
    vtcp_pkg::vout_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vtcp_cfg_if;
    logic             valid;
    logic             ready;
    vtcp_pkg::cfg_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/vertex_transform_clip_project.sv
// ----------------------------------------------------------------------------
// vertex_transform_clip_project
// 4x4 vertex transform, clip outcodes, scale, divide by w and translate
// ----------------------------------------------------------------------------
// sequence: 16 matrix products, each registered then accumulated, a compare state,
// then per axis a digit multiply, a divider start, a wait for the divider and a finish
// step (the finish step alone when transformed w is zero), then output. a new vertex
// is accepted only when idle, once the last result is in the output register
// reset clears the registers to identity matrix, unit scale, zero translate,
// and the outcode accumulators to or 0 and 63
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vertex_transform_clip_project (
    input  wire logic      clk,
    input  wire logic      rst_n,
    vtcp_vin_if.sink       vin,
    vtcp_vout_if.source    vout,
    vtcp_cfg_if.sink       cfg
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MAT  = 8'b0000_0010,
        S_CLIP = 8'b0000_0100,
        S_PMUL = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_WAIT = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [63:0] regs_reg [vtcp_pkg::NumRegs];
    logic [5:0]  or_reg, and_reg;

    logic signed [31:0] v_reg [4];
    logic        last_reg;
    logic signed [63:0] o_reg [4];
    logic [3:0]  step_reg;        // matrix step: row i in [3:2], column j in [1:0]
    logic [1:0]  axis_reg;
    logic [1:0]  pstep_reg;
    logic [5:0]  flag_reg;
    logic [127:0] prod_reg;       // |t|*|scale| accumulated from partial products
    logic signed [63:0] prod_mul_reg; // registered multiplier output
    logic        mul_vld_reg;
    logic signed [31:0] res_reg [3];
    logic        wz_reg;
    vtcp_pkg::vout_t out_reg;
    logic        out_vld_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0] tmag;
    logic [31:0] smag;
    logic signed [31:0] scale_s, trans_s;
    logic signed [15:0] coef_s;
    logic [63:0] pregv;
    vtcp_pkg::div_req_t dreq;
    vtcp_pkg::div_rsp_t drsp;
    logic        neg;
    logic signed [65:0] rsum;
    logic signed [31:0] sat;
    logic [63:0] wmag;
    logic [5:0]  flag_c;
    logic        wz_c;

    assign pregv   = regs_reg[{1'b1, axis_reg}];
    assign scale_s = pregv[31:0];
    assign trans_s = pregv[63:32];
    assign tmag    = o_reg[axis_reg][63] ? 64'(-o_reg[axis_reg]) : o_reg[axis_reg];
    assign smag    = scale_s[31] ? 32'(-scale_s) : scale_s;
    assign wmag    = o_reg[3][63] ? 64'(-o_reg[3]) : o_reg[3];
    assign coef_s  = regs_reg[{1'b0, step_reg[3:2]}][16*step_reg[1:0] +: 16];

    assign flag_c = {o_reg[2] < -o_reg[3], o_reg[2] > o_reg[3],
                     o_reg[1] < -o_reg[3], o_reg[1] > o_reg[3],
                     o_reg[0] < -o_reg[3], o_reg[0] > o_reg[3]};
    assign wz_c   = (o_reg[3] == 0);

    always_comb
    begin
        if (state_reg == S_MAT)
        begin
            mul_a = {v_reg[step_reg[3:2]][31], v_reg[step_reg[3:2]]};
            mul_b = 33'(coef_s);
        end
        else
        begin
            // tmag is below 2^61, split into two 32-bit digits
            mul_a = {1'b0, pstep_reg[1] ? tmag[63:32] : tmag[31:0]};
            mul_b = {1'b0, smag};
        end
        mul_p = mul_a * mul_b;
    end

    assign neg = (o_reg[axis_reg] != 0 && scale_s != 0)
                 && (o_reg[axis_reg][63] != scale_s[31]);
    assign rsum = (neg != o_reg[3][63]) ? (66'sd0 - $signed({2'b00, drsp.quot})) + trans_s
                                        : $signed({2'b00, drsp.quot}) + trans_s;
    always_comb
    begin
        if (wz_reg)
            sat = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (rsum > 66'sh7FFF_FFFF)
            sat = 32'sh7FFF_FFFF;
        else if (rsum < -66'sh8000_0000)
            sat = 32'sh8000_0000;
        else
            sat = rsum[31:0];
    end

    assign dreq.start  = (state_reg == S_DIV);
    assign dreq.num_hi = prod_reg[127:64];
    assign dreq.num_lo = prod_reg[63:0];
    assign dreq.den    = wmag;

    vtcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign vin.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign vout.valid = out_vld_reg;
    assign vout.payload = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (vin.valid && vin.ready) state_next = S_MAT;
            S_MAT:  if (step_reg == 4'd15 && mul_vld_reg) state_next = S_CLIP;
            S_CLIP: state_next = wz_c ? S_FIN : S_PMUL;
            S_PMUL: if (pstep_reg == 2'd3) state_next = S_DIV;
            S_DIV:  state_next = S_WAIT;
            S_WAIT: if (drsp.done) state_next = S_FIN;
            S_FIN:  state_next = (axis_reg == 2'd2) ? S_OUT : (wz_reg ? S_FIN : S_PMUL);
            S_OUT:  if (!out_vld_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            regs_reg[0] <= 64'h0000_0000_0000_1000;
            regs_reg[1] <= 64'h0000_0000_1000_0000;
            regs_reg[2] <= 64'h0000_1000_0000_0000;
            regs_reg[3] <= 64'h1000_0000_0000_0000;
            regs_reg[4] <= 64'h1_0000;
            regs_reg[5] <= 64'h1_0000;
            regs_reg[6] <= 64'h1_0000;
            or_reg      <= '0;
            and_reg     <= '1;
            out_vld_reg <= 1'b0;
            step_reg    <= '0;
            axis_reg    <= '0;
            pstep_reg   <= '0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && {1'b0, cfg.payload.index} < 4'(vtcp_pkg::NumRegs))
                regs_reg[cfg.payload.index] <= cfg.payload.data;
            if (vout.valid && vout.ready)
                out_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    step_reg    <= '0;
                    axis_reg    <= '0;
                    pstep_reg   <= '0;
                    mul_vld_reg <= 1'b0;
                end
                S_MAT:
                begin
                    // the product is registered first, then accumulated and the step advances
                    mul_vld_reg <= !mul_vld_reg;
                    if (mul_vld_reg)
                        step_reg <= step_reg + 4'd1;
                end
                S_CLIP:
                begin
                    or_reg  <= or_reg | flag_c;
                    and_reg <= and_reg & flag_c;
                end
                S_PMUL: pstep_reg <= pstep_reg + 2'd1;
                S_FIN:
                begin
                    pstep_reg <= '0;
                    axis_reg  <= axis_reg + 2'd1;
                end
                S_OUT:
                begin
                    if (!out_vld_reg)
                    begin
                        out_vld_reg <= 1'b1;
                        if (last_reg)
                        begin
                            or_reg  <= '0;
                            and_reg <= '1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_mul_reg <= mul_p[63:0];
        case (state_reg)
            S_IDLE:
            begin
                v_reg[0] <= vin.payload.in_x;
                v_reg[1] <= vin.payload.in_y;
                v_reg[2] <= vin.payload.in_z;
                v_reg[3] <= vin.payload.in_w;
                last_reg <= vin.payload.last_vertex;
                o_reg[0] <= '0;
                o_reg[1] <= '0;
                o_reg[2] <= '0;
                o_reg[3] <= '0;
            end
            S_MAT:
                if (mul_vld_reg)
                    o_reg[step_reg[1:0]] <= o_reg[step_reg[1:0]] + prod_mul_reg;
            S_CLIP:
            begin
                flag_reg <= flag_c;
                wz_reg   <= wz_c;
                prod_reg <= '0;
            end
            S_PMUL:
            begin
                // step 0 and 2 issue digits, 1 and 3 accumulate
                if (pstep_reg == 2'd1)
                    prod_reg <= {64'd0, prod_mul_reg};
                else if (pstep_reg == 2'd3)
                    prod_reg <= prod_reg + {32'd0, prod_mul_reg, 32'd0};
            end
            S_FIN:
            begin
                res_reg[axis_reg] <= sat;
                prod_reg <= '0;
            end
            S_OUT:
            begin
                // hold the waiting item until it is taken
                if (!out_vld_reg)
                begin
                    out_reg.out_x     <= res_reg[0];
                    out_reg.out_y     <= res_reg[1];
                    out_reg.out_z     <= res_reg[2];
                    out_reg.clip_code <= flag_reg;
                    out_reg.codes_or  <= or_reg;
                    out_reg.codes_and <= and_reg;
                    out_reg.w_zero    <= wz_reg;
                    out_reg.list_end  <= last_reg;
                end
            end
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_one_hot, clk, rst_n, $onehot(state_reg))
    `ASSERT_IMPL(a_out_hold, clk, rst_n, vout.valid && !vout.ready |=> vout.valid && $stable(vout.payload))
    `ASSERT_IMPL(a_div_only_wait, clk, rst_n, drsp.done |-> $past(state_reg) == S_WAIT)
endmodule
`default_nettype wire

FILE: hdl/vtcp_div.sv
// ----------------------------------------------------------------------------
// vtcp_div
// restoring divider, 128 by 64 bits, one quotient bit per cycle, capped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vtcp_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vtcp_pkg::div_req_t req,
    output vtcp_pkg::div_rsp_t      rsp
);
    logic [127:0] num_reg, num_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  den_reg, den_next;
    logic [63:0]  quot_reg, quot_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [64:0]  shifted;
    logic [64:0]  diff;
    logic [63:0]  q_new;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[63:0], num_reg[127]};
        diff      = shifted - {1'b0, den_reg};
        q_new     = {quot_reg[62:0], 1'b0};
        if (req.start)
        begin
            num_next  = {req.num_hi, req.num_lo};
            den_next  = req.den;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next = diff;
                q_new[0] = 1'b1;
            end
            else
            begin
                rem_next = shifted;
            end
            // quotient is clamped each step like the long division it models
            if (quot_reg[63] || q_new > vtcp_pkg::QuotCap)
                quot_next = vtcp_pkg::QuotCap;
            else
                quot_next = q_new;
            num_next = {num_reg[126:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule
`default_nettype wire

FILE: bench/vertex_transform_clip_project_tb.sv
// ----------------------------------------------------------------------------
// vertex_transform_clip_project_tb
// self-checking bench: matrix transform, clip outcodes, projection by w
// ----------------------------------------------------------------------------
// a queue of vertices feeds a clocked driver; a clocked monitor compares each
// result against a predicted vertex computed at acceptance time. phases vary
// the idling on both sides and the matrix and projection registers.
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_clip_project_tb;

    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles = 600;

    logic clk;
    logic rst_n;

    vtcp_vin_if  vin ();
    vtcp_vout_if vout ();
    vtcp_cfg_if  cfg ();

    vertex_transform_clip_project uut (
        .clk(clk),
        .rst_n(rst_n),
        .vin(vin.sink),
        .vout(vout.source),
        .cfg(cfg.sink)
    );

    logic [63:0] coef_regs [0:vtcp_pkg::NumRegs-1];
    logic [5:0]  or_acc;
    logic [5:0]  and_acc;

    vtcp_pkg::vin_t  pending_vertices [$];
    vtcp_pkg::vout_t expected_vertices [$];

    int  src_idle_pct;
    int  dst_stall_pct;
    bit  feed_hold;
    int  mismatches;
    int  idle_cycles;
    bit  timed_out;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [31:0] project_axis(
        input logic signed [63:0] t, input logic signed [63:0] w,
        input logic [63:0] preg, input bit wz);
        logic signed [63:0]  scale;
        logic signed [63:0]  trans;
        bit                  neg;
        logic [127:0]        prod;
        logic [127:0]        quot;
        logic [63:0]         tm;
        logic [63:0]         sm;
        logic [63:0]         wm;
        logic signed [65:0]  r;
        begin
            scale = {{32{preg[31]}}, preg[31:0]};
            trans = {{32{preg[63]}}, preg[63:32]};
            neg = (t != 0 && scale != 0) && ((t < 0) != (scale < 0));
            if (wz)
                return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
            tm = t < 0 ? -t : t;
            sm = scale < 0 ? -scale : scale;
            wm = w < 0 ? -w : w;
            prod = tm * sm;
            quot = prod / wm;
            // the divider caps its quotient, which still saturates afterward
            if (quot > vtcp_pkg::QuotCap)
                quot = vtcp_pkg::QuotCap;
            if (w < 0)
                neg = !neg;
            r = neg ? -$signed({2'b0, quot[63:0]}) : $signed({2'b0, quot[63:0]});
            r = r + trans;
            if (r > 66'sd2147483647)
                r = 66'sd2147483647;
            if (r < -66'sd2147483648)
                r = -66'sd2147483648;
            return r[31:0];
        end
    endfunction

    function automatic vtcp_pkg::vout_t transform_vertex(input vtcp_pkg::vin_t v);
        logic signed [63:0] comp [0:3];
        logic signed [63:0] o [0:3];
        logic signed [15:0] c;
        vtcp_pkg::vout_t    res;
        logic [5:0]         code;
        bit                 wz;
        begin
            comp[0] = v.in_x;
            comp[1] = v.in_y;
            comp[2] = v.in_z;
            comp[3] = v.in_w;
            for (int j = 0; j < 4; j++)
            begin
                o[j] = 0;
                for (int i = 0; i < 4; i++)
                begin
                    c = coef_regs[i][16*j +: 16];
                    o[j] = o[j] + comp[i] * c;
                end
            end
            code = 6'd0;
            if (o[0] > o[3])  code[0] = 1'b1;
            if (o[0] < -o[3]) code[1] = 1'b1;
            if (o[1] > o[3])  code[2] = 1'b1;
            if (o[1] < -o[3]) code[3] = 1'b1;
            if (o[2] > o[3])  code[4] = 1'b1;
            if (o[2] < -o[3]) code[5] = 1'b1;
            or_acc = or_acc | code;
            and_acc = and_acc & code;
            wz = (o[3] == 0);
            res.out_x = project_axis(o[0], o[3], coef_regs[4], wz);
            res.out_y = project_axis(o[1], o[3], coef_regs[5], wz);
            res.out_z = project_axis(o[2], o[3], coef_regs[6], wz);
            res.clip_code = code;
            res.codes_or = or_acc;
            res.codes_and = and_acc;
            res.w_zero = wz;
            res.list_end = v.last_vertex;
            if (v.last_vertex)
            begin
                or_acc = 6'd0;
                and_acc = 6'h3f;
            end
            return res;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin.valid <= 1'b0;
            vin.payload <= '0;
        end
        else
        begin
            if (vin.valid && vin.ready)
                expected_vertices.push_back(transform_vertex(vin.payload));
            if (!vin.valid || vin.ready)
            begin
                if (pending_vertices.size() > 0 && !feed_hold &&
                    $urandom_range(99) >= src_idle_pct)
                begin
                    vin.valid <= 1'b1;
                    vin.payload <= pending_vertices.pop_front();
                end
                else
                    vin.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout.ready <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (vout.valid && vout.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item %p", vout.payload);
                end
                else
                begin
                    vtcp_pkg::vout_t e;
                    e = expected_vertices.pop_front();
                    if (e.out_x !== vout.payload.out_x || e.out_y !== vout.payload.out_y ||
                        e.out_z !== vout.payload.out_z ||
                        e.clip_code !== vout.payload.clip_code ||
                        e.codes_or !== vout.payload.codes_or ||
                        e.codes_and !== vout.payload.codes_and ||
                        e.w_zero !== vout.payload.w_zero ||
                        e.list_end !== vout.payload.list_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch expected %p actual %p", e, vout.payload);
                    end
                end
            end
            vout.ready <= ($urandom_range(99) >= dst_stall_pct);
            if ((vin.valid && vin.ready) || (vout.valid && vout.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WatchdogLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input int idx, input logic [63:0] value);
        begin
            @(posedge clk);
            cfg.valid <= 1'b1;
            cfg.payload <= '{index: idx[vtcp_pkg::IdxW-1:0], data: value};
            do
                @(posedge clk);
            while (!cfg.ready);
            cfg.valid <= 1'b0;
            if (idx < vtcp_pkg::NumRegs)
                coef_regs[idx] = value;
        end
    endtask

    task automatic drain();
        begin
            while (pending_vertices.size() > 0 || vin.valid || expected_vertices.size() > 0)
                @(posedge clk);
            repeat (SettleCycles) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($urandom_range(32'h000f_ffff)) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_coef(input bit diag);
        case ($urandom_range(4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return diag ? 16'h1000 + 16'($urandom_range(511)) - 16'd256 :
                16'($urandom_range(1023)) - 16'd512;
        endcase
    endfunction

    task automatic queue_random(input int count);
        vtcp_pkg::vin_t v;
        begin
            for (int n = 0; n < count; n++)
            begin
                v.in_x = pick_coord();
                v.in_y = pick_coord();
                v.in_z = pick_coord();
                v.in_w = ($urandom_range(9) == 0) ? 32'h0 : pick_coord();
                v.last_vertex = ($urandom_range(5) == 0);
                pending_vertices.push_back(v);
            end
        end
    endtask

    task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
        input logic [31:0] z, input logic [31:0] w, input bit last);
        begin
            pending_vertices.push_back('{x, y, z, w, last});
        end
    endtask

    initial
    begin
        logic [63:0] val;
        rst_n = 1'b0;
        vin.valid = 1'b0;
        vin.payload = '0;
        vout.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.payload = '0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        feed_hold = 1'b0;
        mismatches = 0;
        timed_out = 1'b0;
        coef_regs[0] = 64'h0000_0000_0000_1000;
        coef_regs[1] = 64'h0000_0000_1000_0000;
        coef_regs[2] = 64'h0000_1000_0000_0000;
        coef_regs[3] = 64'h1000_0000_0000_0000;
        coef_regs[4] = 64'h1_0000;
        coef_regs[5] = 64'h1_0000;
        coef_regs[6] = 64'h1_0000;
        or_acc = 6'd0;
        and_acc = 6'h3f;
        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero w both signs, clip on each side, list ends
        queue_vertex(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0004_0000, 1'b0);
        queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b0);
        queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1);
        queue_vertex(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0, 1'b0);
        queue_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        queue_vertex(32'h0005_0000, 32'hfffb_0000, 32'h0005_0000, 32'h0001_0000, 1'b0);
        queue_vertex(32'hfffb_0000, 32'h0005_0000, 32'hfffb_0000, 32'hffff_0000, 1'b1);
        queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
        queue_vertex(32'hffff_ffff, 32'h0000_0001, 32'h7fff_0000, 32'h7fff_ffff, 1'b1);
        drain();

        // directed with extreme projection and translate
        write_reg(4, 64'h7fff_ffff_7fff_ffff);
        write_reg(5, 64'h8000_0000_8000_0000);
        write_reg(6, 64'h0000_0000_0000_0000);
        queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 1'b0);
        queue_vertex(32'hffff_0000, 32'hffff_0000, 32'h0001_0000, 32'h0, 1'b0);
        queue_vertex(32'h0, 32'h0, 32'h0, 32'h0010_0000, 1'b1);
        drain();
        write_reg(0, 64'h8000_7fff_8000_7fff);
        write_reg(1, 64'hffff_ffff_ffff_ffff);
        write_reg(2, 64'h0);
        write_reg(3, 64'h7fff_8000_7fff_8000);
        write_reg(7, 64'hdead_beef_dead_beef);
        queue_random(10);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 73; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 73; end
                default: begin src_idle_pct = 14; dst_stall_pct = 14; end
            endcase
            for (int r = 0; r < vtcp_pkg::NumRegs; r++)
            begin
                if (phase == 0)
                    val = coef_regs[r];
                else if (r < 4)
                    for (int k = 0; k < 4; k++)
                        val[16*k +: 16] = pick_coef(k == r);
                else
                    val = {$urandom_range(1) ? 32'($urandom) :
                        32'($urandom_range(32'h000f_ffff)) - 32'h0008_0000,
                        $urandom_range(3) == 0 ? 32'($urandom) :
                        32'h0001_0000 + 32'($urandom_range(32'h0003_ffff)) -
                        32'h0002_0000};
                write_reg(r, val);
            end
            queue_random(80);
            // pause feeding until every pending result is back
            while (pending_vertices.size() > 0 || vin.valid)
                @(posedge clk);
            feed_hold <= 1'b1;
            while (expected_vertices.size() > 0)
                @(posedge clk);
            feed_hold <= 1'b0;
            queue_random(90);
            drain();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
